// ===== hdl/ryuv_pkg.sv =====
// ryuv_pkg: shared types and constants for the RGB to YUV 4:2:0 subsampler.
// Holds payload structs, register indexes, plane codes and BT.601 coefficients.
// No dependencies.
package ryuv_pkg;

   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int HEIGHT_CAP        = 4096;
   localparam int WIDTH_LIMIT       = 4096;

   localparam int CHAN_W  = 8;
   localparam int PAIR_W  = 9;
   localparam int SUM_W   = 10;
   localparam int PROD_W  = 16;
   localparam int COORD_W = 12;
   localparam int SIZE_W  = 13;
   localparam int LINE_W  = 3 * PAIR_W;
   localparam int CSR_INDEX_W = 2;

   localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam logic [PROD_W-1:0] Y_R_COEF  = 16'd66;
   localparam logic [PROD_W-1:0] Y_G_COEF  = 16'd129;
   localparam logic [PROD_W-1:0] Y_B_COEF  = 16'd25;
   localparam logic [CHAN_W-1:0] Y_OFFSET  = 8'd16;
   localparam logic [PROD_W-1:0] CB_R_COEF = 16'd38;
   localparam logic [PROD_W-1:0] CB_G_COEF = 16'd74;
   localparam logic [PROD_W-1:0] CB_B_COEF = 16'd112;
   localparam logic [PROD_W-1:0] CR_R_COEF = 16'd112;
   localparam logic [PROD_W-1:0] CR_G_COEF = 16'd94;
   localparam logic [PROD_W-1:0] CR_B_COEF = 16'd18;
   localparam logic [CHAN_W-1:0] C_OFFSET  = 8'd128;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_GRAY_MODE    = 2'd2
   } csr_index_type;

   typedef enum logic {
      PLANE_LUMA   = 1'b0,
      PLANE_CHROMA = 1'b1
   } plane_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } req_type;

   typedef struct packed {
      plane_type          plane;
      logic [CHAN_W-1:0]  first_value;
      logic [CHAN_W-1:0]  second_value;
      logic [COORD_W-1:0] out_column;
      logic [COORD_W-1:0] out_row;
      logic               last_of_run;
   } rsp_type;

endpackage

// ===== hdl/ryuv_ram.sv =====
// ryuv_ram: generic simple dual-port RAM, one write and one registered read port.
// Used as the line store of the subsampler. No dependencies.
module ryuv_ram #(
   parameter int WIDTH      = 27,
   parameter int DEPTH      = 2048,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rgb_to_yuv420_subsampler.sv =====
// rgb_to_yuv420_subsampler: BT.601 RGB to YCbCr 4:2:0 converter, top level.
// Depends on ryuv_pkg and ryuv_ram.
//
// Usage:
//   req_*  : one RGB pixel per beat, raster order, valid/stall handshake.
//   rsp_*  : results, one per beat. Every pixel gives a luma beat; a pixel
//            that closes a 2x2 block also gives a chroma beat (Cb, Cr) right
//            after its luma beat, and only the final beat of a pixel has
//            last_of_run set.
//   csr_*  : register writes (frame_width, frame_height, gray_mode); always
//            ready; the user writes them only while the block is idle, which the block does not enforce.
// A luma beat passes stage 1, stage 2 and the output register after its pixel is taken.
// Throughput: one pixel per cycle while the output is not stalled; the output port carries
//   one beat per cycle, so pixels with a chroma beat hold the input back.
// Even-row pair sums live in the line RAM (one entry per column pair);
//   odd rows read them back as their pixel enters stage 1, ready for the multiply stage.
// Reset clears position, held pixel and pipeline valids; the line RAM is not
//   cleared. When rsp_stall is high the output beat holds, the pipeline fills
//   behind it and req_stall rises once both stages are occupied.
module rgb_to_yuv420_subsampler #(
   parameter int MAX_WIDTH = ryuv_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ryuv_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ryuv_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ryuv_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ryuv_pkg::SIZE_W-1:0]          csr_data
);

   localparam int WIDTH_CAP  = (MAX_WIDTH < ryuv_pkg::WIDTH_LIMIT) ? MAX_WIDTH
                                                                   : ryuv_pkg::WIDTH_LIMIT;
   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   localparam int CW = ryuv_pkg::CHAN_W;
   localparam int PW = ryuv_pkg::PAIR_W;
   localparam int SW = ryuv_pkg::SUM_W;
   localparam int XW = ryuv_pkg::PROD_W;
   localparam int KW = ryuv_pkg::COORD_W;
   localparam int ZW = ryuv_pkg::SIZE_W;

   typedef struct packed {
      logic [KW-1:0] col;
      logic [KW-1:0] row;
      logic [CW-1:0] red;
      logic [CW-1:0] green;
      logic [CW-1:0] blue;
      logic [PW-1:0] pr;
      logic [PW-1:0] pg;
      logic [PW-1:0] pb;
      logic          has_chroma;
      logic          row_odd;
   } s1_type;

   typedef struct packed {
      logic [KW-1:0] col;
      logic [KW-1:0] row;
      logic [CW-1:0] red;
      logic          has_chroma;
      logic [XW-1:0] y_r;
      logic [XW-1:0] y_g;
      logic [XW-1:0] y_b;
      logic [XW-1:0] cb_r;
      logic [XW-1:0] cb_g;
      logic [XW-1:0] cb_b;
      logic [XW-1:0] cr_r;
      logic [XW-1:0] cr_g;
      logic [XW-1:0] cr_b;
   } s2_type;

   // chroma finish: (pos - neg_a - neg_b + 128) / 256 truncated toward zero, + 128
   function automatic logic [CW-1:0] chroma_finish(input logic [XW-1:0] pos,
                                                   input logic [XW-1:0] neg_a,
                                                   input logic [XW-1:0] neg_b);
      logic signed [XW+1:0] num;
      logic signed [XW+1:0] quo;
      num = $signed({2'b00, pos}) + (XW+2)'(128)
            - $signed({2'b00, neg_a}) - $signed({2'b00, neg_b});
      if (num[XW+1]) begin
         quo = (num + (XW+2)'(255)) >>> 8;
      end else begin
         quo = num >>> 8;
      end
      return quo[CW-1:0] + ryuv_pkg::C_OFFSET;
   endfunction

   // configuration
   logic [ZW-1:0] frame_width_ff;
   logic [ZW-1:0] frame_height_ff;
   logic          gray_mode_ff;

   // position and held pixel
   logic [KW-1:0]     pcol_ff, pcol_in;
   logic [KW-1:0]     prow_ff, prow_in;
   ryuv_pkg::req_type held_ff, held_in;

   // pipeline
   logic              s1_valid_ff, s1_valid_in;
   s1_type            s1_ff, s1_in;
   logic              s2_valid_ff, s2_valid_in;
   logic              s2_phase_ff, s2_phase_in;
   s2_type            s2_ff, s2_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ryuv_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [ZW-1:0] eff_w, eff_h;
   logic          accept, wrap_in, col_end, row_last, col_odd, row_odd, pair_done;
   logic [KW-1:0] col_cur, row_cur;
   logic [ZW-1:0] row_pre, col_next, row_next;
   logic [PW-1:0] pr, pg, pb;

   logic               ram_we, ram_re;
   logic [LINE_AW-1:0] ram_addr;
   logic [ryuv_pkg::LINE_W-1:0] ram_q;

   logic [SW-1:0] sr, sg, sb, tr, tg, tb;
   logic [CW-1:0] ar, ag, ab;

   logic          out_free, s2_emit, s2_done, s1_move, s1_free;
   logic [XW:0]   y_sum;
   logic [CW-1:0] y_val, cb_val, cr_val;

   assign csr_ready = 1'b1;

   always_comb begin
      eff_w = frame_width_ff;
      if (frame_width_ff == '0) begin
         eff_w = ZW'(1);
      end else if (frame_width_ff > ZW'(WIDTH_CAP)) begin
         eff_w = ZW'(WIDTH_CAP);
      end
      eff_h = frame_height_ff;
      if (frame_height_ff == '0) begin
         eff_h = ZW'(1);
      end else if (frame_height_ff > ZW'(ryuv_pkg::HEIGHT_CAP)) begin
         eff_h = ZW'(ryuv_pkg::HEIGHT_CAP);
      end
   end

   // position of the incoming pixel and of the next one
   always_comb begin
      wrap_in  = {1'b0, pcol_ff} >= eff_w;
      col_cur  = wrap_in ? '0 : pcol_ff;
      row_pre  = wrap_in ? {1'b0, prow_ff} + ZW'(1) : {1'b0, prow_ff};
      row_cur  = (row_pre >= eff_h) ? '0 : row_pre[KW-1:0];
      col_next = {1'b0, col_cur} + ZW'(1);
      row_next = {1'b0, row_cur} + ZW'(1);
      col_end  = col_next >= eff_w;
      row_last = row_next >= eff_h;
      col_odd  = col_cur[0];
      row_odd  = row_cur[0];
      pair_done = col_odd || col_end;
      if (col_end) begin
         pcol_in = '0;
         prow_in = row_last ? '0 : row_next[KW-1:0];
      end else begin
         pcol_in = col_next[KW-1:0];
         prow_in = row_cur;
      end
   end

   always_comb begin
      if (col_odd) begin
         pr = {1'b0, held_ff.red}   + {1'b0, req_data.red};
         pg = {1'b0, held_ff.green} + {1'b0, req_data.green};
         pb = {1'b0, held_ff.blue}  + {1'b0, req_data.blue};
      end else begin
         pr = {req_data.red,   1'b0};
         pg = {req_data.green, 1'b0};
         pb = {req_data.blue,  1'b0};
      end
      held_in = (accept && !col_odd) ? req_data : held_ff;
   end

   assign accept   = req_valid && !req_stall;
   assign ram_we   = accept && pair_done && !row_odd;
   assign ram_re   = accept && pair_done && row_odd;
   assign ram_addr = LINE_AW'(col_cur >> 1);

   ryuv_ram #(
      .WIDTH (ryuv_pkg::LINE_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data ({pb, pg, pr}),
      .rd_en   (ram_re),
      .rd_addr (ram_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      s1_in.col        = col_cur;
      s1_in.row        = row_cur;
      s1_in.red        = req_data.red;
      s1_in.green      = req_data.green;
      s1_in.blue       = req_data.blue;
      s1_in.pr         = pr;
      s1_in.pg         = pg;
      s1_in.pb         = pb;
      s1_in.has_chroma = pair_done && (row_odd || row_last);
      s1_in.row_odd    = row_odd;
   end

   // block sums, averages and products
   always_comb begin
      if (s1_ff.row_odd) begin
         sr = {1'b0, s1_ff.pr} + {1'b0, ram_q[PW-1:0]};
         sg = {1'b0, s1_ff.pg} + {1'b0, ram_q[2*PW-1:PW]};
         sb = {1'b0, s1_ff.pb} + {1'b0, ram_q[3*PW-1:2*PW]};
      end else begin
         sr = {s1_ff.pr, 1'b0};
         sg = {s1_ff.pg, 1'b0};
         sb = {s1_ff.pb, 1'b0};
      end
      tr = sr + SW'(2);
      tg = sg + SW'(2);
      tb = sb + SW'(2);
      ar = tr[SW-1:2];
      ag = tg[SW-1:2];
      ab = tb[SW-1:2];
      s2_in.col        = s1_ff.col;
      s2_in.row        = s1_ff.row;
      s2_in.red        = s1_ff.red;
      s2_in.has_chroma = s1_ff.has_chroma;
      s2_in.y_r  = {8'd0, s1_ff.red}   * ryuv_pkg::Y_R_COEF;
      s2_in.y_g  = {8'd0, s1_ff.green} * ryuv_pkg::Y_G_COEF;
      s2_in.y_b  = {8'd0, s1_ff.blue}  * ryuv_pkg::Y_B_COEF;
      s2_in.cb_r = {8'd0, ar} * ryuv_pkg::CB_R_COEF;
      s2_in.cb_g = {8'd0, ag} * ryuv_pkg::CB_G_COEF;
      s2_in.cb_b = {8'd0, ab} * ryuv_pkg::CB_B_COEF;
      s2_in.cr_r = {8'd0, ar} * ryuv_pkg::CR_R_COEF;
      s2_in.cr_g = {8'd0, ag} * ryuv_pkg::CR_G_COEF;
      s2_in.cr_b = {8'd0, ab} * ryuv_pkg::CR_B_COEF;
   end

   // flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_emit   = s2_valid_ff && out_free;
   assign s2_done   = s2_emit && (!s2_ff.has_chroma || s2_phase_ff);
   assign s1_move   = s1_valid_ff && (!s2_valid_ff || s2_done);
   assign s1_free   = !s1_valid_ff || s1_move;
   assign req_stall = !s1_free;

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      s2_valid_in  = s1_move || (s2_valid_ff && !s2_done);
      s2_phase_in  = (s2_done || s1_move) ? 1'b0 : (s2_emit ? 1'b1 : s2_phase_ff);
      rsp_valid_in = s2_emit || (rsp_valid_ff && rsp_stall);
   end

   // result formatting
   always_comb begin
      y_sum  = {1'b0, s2_ff.y_r} + {1'b0, s2_ff.y_g} + {1'b0, s2_ff.y_b} + (XW+1)'(128);
      y_val  = gray_mode_ff ? s2_ff.red : y_sum[XW-1:8] + ryuv_pkg::Y_OFFSET;
      cb_val = gray_mode_ff ? ryuv_pkg::C_OFFSET
                            : chroma_finish(s2_ff.cb_b, s2_ff.cb_r, s2_ff.cb_g);
      cr_val = gray_mode_ff ? ryuv_pkg::C_OFFSET
                            : chroma_finish(s2_ff.cr_r, s2_ff.cr_g, s2_ff.cr_b);
      if (s2_ff.has_chroma && s2_phase_ff) begin
         rsp_data_in.plane        = ryuv_pkg::PLANE_CHROMA;
         rsp_data_in.first_value  = cb_val;
         rsp_data_in.second_value = cr_val;
         rsp_data_in.out_column   = s2_ff.col >> 1;
         rsp_data_in.out_row      = s2_ff.row >> 1;
         rsp_data_in.last_of_run  = 1'b1;
      end else begin
         rsp_data_in.plane        = ryuv_pkg::PLANE_LUMA;
         rsp_data_in.first_value  = y_val;
         rsp_data_in.second_value = '0;
         rsp_data_in.out_column   = s2_ff.col;
         rsp_data_in.out_row      = s2_ff.row;
         rsp_data_in.last_of_run  = !s2_ff.has_chroma;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= ryuv_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= ryuv_pkg::FRAME_HEIGHT_RESET;
         gray_mode_ff    <= 1'b0;
         pcol_ff         <= '0;
         prow_ff         <= '0;
         held_ff         <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s2_phase_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ryuv_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
               ryuv_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
               ryuv_pkg::CSR_GRAY_MODE:    gray_mode_ff    <= csr_data[0];
               default: ;
            endcase
         end
         if (accept) begin
            pcol_ff <= pcol_in;
            prow_ff <= prow_in;
         end
         held_ff      <= held_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s2_phase_ff  <= s2_phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         s2_ff <= s2_in;
      end
      if (s2_emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the line RAM is written on even rows and read on odd rows, never both
   assert property (@(posedge clock) disable iff (reset) !(ram_we && ram_re))
      else $error("line RAM read and write in the same cycle");

   // chroma phase only on an occupied stage that owes a chroma beat
   assert property (@(posedge clock) disable iff (reset)
      s2_phase_ff |-> (s2_valid_ff && s2_ff.has_chroma))
      else $error("chroma phase without pending chroma");

   // a luma beat that is not last is followed at once by its chroma beat
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.plane == ryuv_pkg::PLANE_LUMA
       && !rsp_data.last_of_run)
      |=> (rsp_valid && rsp_data.plane == ryuv_pkg::PLANE_CHROMA))
      else $error("chroma beat missing after luma beat");

endmodule
